// File: src/fdr_pkg.sv
// shared types and constants for the frame delta run encoder
`default_nettype none
package fdr_pkg;

  localparam int PAIRS_PER_ROW  = 160;
  localparam int ROWS_PER_FRAME = 180;
  localparam int STORE_DEPTH    = PAIRS_PER_ROW * ROWS_PER_FRAME;
  localparam int POS_W          = $clog2(STORE_DEPTH);
  localparam int COLOR_W        = 15;
  localparam int CHAN_W         = 5;
  localparam int ENTRY_W        = 2 * COLOR_W;
  localparam int IDX_W          = 8;
  localparam int THR_W          = 12;
  localparam int DIST_W         = 7;
  localparam int CNT8_W         = 8;
  localparam int MAX_BYTES      = 6;
  localparam int NB_W           = 3;
  localparam int IN_DATA_W      = 48;

  localparam logic [CNT8_W-1:0] COL_LAST   = CNT8_W'(PAIRS_PER_ROW - 1);
  localparam logic [CNT8_W-1:0] ROW_LAST   = CNT8_W'(ROWS_PER_FRAME - 1);
  localparam logic [CNT8_W-1:0] FULL_SKIP  = CNT8_W'(PAIRS_PER_ROW);
  localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(STORE_DEPTH - 1);
  localparam logic [7:0]        ROW_MARK   = 8'hc0;
  localparam logic [7:0]        MARK_MAX   = 8'hff;

  localparam logic KIND_CTRL  = 1'b0;
  localparam logic KIND_INDEX = 1'b1;
  localparam logic OP_DELTA   = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } obyte_t;

  typedef struct packed {
    logic [NB_W-1:0]               cnt;
    obyte_t [MAX_BYTES-1:0]        bytes;
  } pkt_t;

  function automatic logic [CHAN_W-1:0] chan_abs(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    chan_abs = (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic is_close(input logic [COLOR_W-1:0] now,
                                    input logic [COLOR_W-1:0] old,
                                    input logic [THR_W-1:0]   thr);
    logic [DIST_W-1:0] d;
    d = DIST_W'(chan_abs(now[14:10], old[14:10]))
      + {1'b0, chan_abs(now[9:5], old[9:5]), 1'b0}
      + DIST_W'(chan_abs(now[4:0], old[4:0]));
    is_close = THR_W'(d) <= thr;
  endfunction

endpackage
`default_nettype wire

// File: src/fdr_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module fdr_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 28800
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/fdr_encode.sv
// compare and run encode stage, builds the byte packet for one pair
`default_nettype none
module fdr_encode (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [fdr_pkg::THR_W-1:0]    cfg_wdata,
  input  wire logic                         go,
  input  wire logic                         op,
  input  wire logic [fdr_pkg::IDX_W-1:0]    first_index,
  input  wire logic [fdr_pkg::COLOR_W-1:0]  first_color,
  input  wire logic [fdr_pkg::IDX_W-1:0]    second_index,
  input  wire logic [fdr_pkg::COLOR_W-1:0]  second_color,
  input  wire logic [fdr_pkg::ENTRY_W-1:0]  old_entry,
  output fdr_pkg::pkt_t                     pkt,
  output logic                              store_we,
  output logic      [fdr_pkg::ENTRY_W-1:0]  store_wdata
);

  logic [fdr_pkg::THR_W-1:0]  threshold;
  logic [fdr_pkg::CNT8_W-1:0] pair_column, pair_column_next;
  logic [fdr_pkg::CNT8_W-1:0] row_number, row_number_next;
  logic                       skipping, skipping_next;
  logic [fdr_pkg::CNT8_W-1:0] skip_count, skip_count_next;
  logic [fdr_pkg::CNT8_W-1:0] copy_count, copy_count_next;
  logic [7:0]                 pending_marker, pending_marker_next;
  logic                       marker_valid, marker_valid_next;
  logic                       same;

  function automatic fdr_pkg::pkt_t push(input fdr_pkg::pkt_t p, input logic kind,
                                         input logic [7:0] val, input logic last);
    fdr_pkg::pkt_t q;
    q = p;
    q.bytes[p.cnt].kind  = kind;
    q.bytes[p.cnt].value = val;
    q.bytes[p.cnt].last  = last;
    q.cnt = p.cnt + fdr_pkg::NB_W'(1);
    return q;
  endfunction

  assign same = fdr_pkg::is_close(first_color, old_entry[fdr_pkg::COLOR_W-1:0], threshold) &&
                fdr_pkg::is_close(second_color, old_entry[fdr_pkg::ENTRY_W-1:fdr_pkg::COLOR_W],
                                  threshold);
  assign store_wdata = {second_color, first_color};

  always_comb begin
    pkt                 = '0;
    store_we            = 1'b0;
    pair_column_next    = pair_column;
    row_number_next     = row_number;
    skipping_next       = skipping;
    skip_count_next     = skip_count;
    copy_count_next     = copy_count;
    pending_marker_next = pending_marker;
    marker_valid_next   = marker_valid;
    if (go) begin
      if (op == fdr_pkg::OP_LOAD) begin
        store_we = 1'b1;
      end else begin
        if (same != skipping_next) begin
          if (marker_valid_next) begin
            pkt = push(pkt, fdr_pkg::KIND_CTRL, pending_marker_next, 1'b0);
            marker_valid_next = 1'b0;
          end
          pkt = push(pkt, fdr_pkg::KIND_CTRL,
                     skipping_next ? skip_count_next : copy_count_next, 1'b0);
          skipping_next   = !skipping_next;
          skip_count_next = '0;
          copy_count_next = '0;
        end
        if (!skipping_next) begin
          if (marker_valid_next) begin
            pkt = push(pkt, fdr_pkg::KIND_CTRL, pending_marker_next, 1'b0);
            marker_valid_next = 1'b0;
          end
          pkt = push(pkt, fdr_pkg::KIND_INDEX, first_index, 1'b0);
          pkt = push(pkt, fdr_pkg::KIND_INDEX, second_index, 1'b0);
          store_we        = 1'b1;
          copy_count_next = copy_count_next + fdr_pkg::CNT8_W'(1);
        end else begin
          skip_count_next = skip_count_next + fdr_pkg::CNT8_W'(1);
        end
      end

      pair_column_next = pair_column + fdr_pkg::CNT8_W'(1);
      if (pair_column == fdr_pkg::COL_LAST) begin
        pair_column_next = '0;
        if (op == fdr_pkg::OP_DELTA) begin
          if (!skipping_next) begin
            if (marker_valid_next) begin
              pkt = push(pkt, fdr_pkg::KIND_CTRL, pending_marker_next, 1'b0);
              marker_valid_next = 1'b0;
            end
            pkt = push(pkt, fdr_pkg::KIND_CTRL, copy_count_next, 1'b0);
          end
          if (skipping_next && skip_count_next == fdr_pkg::FULL_SKIP &&
              marker_valid_next && pending_marker_next != fdr_pkg::MARK_MAX) begin
            pending_marker_next = pending_marker_next + 8'd1;
          end else begin
            if (marker_valid_next) begin
              pkt = push(pkt, fdr_pkg::KIND_CTRL, pending_marker_next, 1'b0);
            end
            pending_marker_next = fdr_pkg::ROW_MARK;
            marker_valid_next   = 1'b1;
          end
        end
        skipping_next   = 1'b1;
        skip_count_next = '0;
        copy_count_next = '0;
        row_number_next = row_number + fdr_pkg::CNT8_W'(1);
        if (row_number == fdr_pkg::ROW_LAST) begin
          row_number_next = '0;
          if (op == fdr_pkg::OP_DELTA && marker_valid_next) begin
            pkt = push(pkt, fdr_pkg::KIND_CTRL, pending_marker_next, 1'b1);
          end
          marker_valid_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= '0;
      pair_column    <= '0;
      row_number     <= '0;
      skipping       <= 1'b1;
      skip_count     <= '0;
      copy_count     <= '0;
      pending_marker <= '0;
      marker_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      pair_column    <= pair_column_next;
      row_number     <= row_number_next;
      skipping       <= skipping_next;
      skip_count     <= skip_count_next;
      copy_count     <= copy_count_next;
      pending_marker <= pending_marker_next;
      marker_valid   <= marker_valid_next;
    end
  end

endmodule
`default_nettype wire

// File: src/fdr_out.sv
// result register, shifts a packet of bytes out one per request
`default_nettype none
module fdr_out (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire fdr_pkg::pkt_t pkt,
  output logic               free,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [7:0]         m_axis_tdata,
  output logic               m_axis_tuser,
  output logic               m_axis_tlast,
  output logic [fdr_pkg::NB_W-1:0] fill
);

  fdr_pkg::obyte_t [fdr_pkg::MAX_BYTES-1:0] ent;
  logic [fdr_pkg::NB_W-1:0] cnt;
  logic                     take;

  assign take          = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = cnt != '0;
  assign m_axis_tdata  = ent[0].value;
  assign m_axis_tuser  = ent[0].kind;
  assign m_axis_tlast  = ent[0].last;
  assign free          = (cnt == '0) || (cnt == fdr_pkg::NB_W'(1) && m_axis_tready);
  assign fill          = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= pkt.cnt;
    end else if (take) begin
      cnt <= cnt - fdr_pkg::NB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= pkt.bytes;
    end else if (take) begin
      for (int i = 0; i < fdr_pkg::MAX_BYTES - 1; i++) begin
        ent[i] <= ent[i+1];
      end
    end
  end

endmodule
`default_nettype wire

// File: src/frame_delta_run_encoder_top.sv
// frame delta run encoder top level: input register, reference store, encoder, output
// Usage:
//   slave stream takes one pixel pair per request: s_axis_tuser is the operation
//   (delta encode or reference load), s_axis_tdata the two indices and colors.
//   master stream gives one byte per request: tuser is the byte kind (control or
//   index), tlast marks the final marker of a frame.
//   cfg_we/cfg_wdata set the change threshold; write only while idle.
// Path: a pair is taken into the input register while the store is read; when the
//   output register is free, the pair is encoded into it and its first byte becomes
//   valid on the master side.
// Throughput: a pair's k bytes hold the output register until taken, k at most 6;
//   pairs producing at most one byte stream at one per cycle while the master
//   side is ready. The output register drains while the next pair waits in the
//   input register, so the slave side takes one more pair while a result waits.
// Reset: position, run state and pending marker clear, threshold goes to zero;
//   the reference store is not cleared and must be loaded before delta pairs
//   read it.
// Stall: when the master side stalls, the byte packet holds, the next pair waits
//   in the input register and s_axis_tready drops once both are full.
`default_nettype none
module frame_delta_run_encoder_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [fdr_pkg::THR_W-1:0]        cfg_wdata,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // first_index, first_color, second_index, second_color, zero fill
  input  wire logic [fdr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // byte_value
  output logic      [7:0]                       m_axis_tdata,
  // byte_kind
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);

  logic                               in_valid;
  logic                               in_op;
  logic [fdr_pkg::IN_DATA_W-1:0]      in_data;
  logic [fdr_pkg::POS_W-1:0]          in_pos;
  logic [fdr_pkg::POS_W-1:0]          rd_pos;
  logic                               s_take;
  logic                               go;
  logic                               out_free;
  logic [fdr_pkg::ENTRY_W-1:0]        old_entry;
  logic                               store_we;
  logic [fdr_pkg::ENTRY_W-1:0]        store_wdata;
  logic [fdr_pkg::NB_W-1:0]           out_fill;
  fdr_pkg::pkt_t                      pkt;

  assign go            = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rd_pos   <= '0;
    end else begin
      if (s_take) begin
        in_valid <= 1'b1;
        rd_pos   <= (rd_pos == fdr_pkg::POS_LAST) ? '0 : rd_pos + fdr_pkg::POS_W'(1);
      end else if (go) begin
        in_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      in_op   <= s_axis_tuser;
      in_data <= s_axis_tdata;
      in_pos  <= rd_pos;
    end
  end

  fdr_ram #(
    .WIDTH (fdr_pkg::ENTRY_W),
    .DEPTH (fdr_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (in_pos),
    .wdata (store_wdata),
    .re    (s_take),
    .raddr (rd_pos),
    .rdata (old_entry)
  );

  fdr_encode u_encode (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .go           (go),
    .op           (in_op),
    .first_index  (in_data[7:0]),
    .first_color  (in_data[22:8]),
    .second_index (in_data[30:23]),
    .second_color (in_data[45:31]),
    .old_entry    (old_entry),
    .pkt          (pkt),
    .store_we     (store_we),
    .store_wdata  (store_wdata)
  );

  fdr_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (go),
    .pkt           (pkt),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fill          (out_fill)
  );

`ifndef SYNTHESIS
  a_last_is_marker: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tuser == fdr_pkg::KIND_CTRL && m_axis_tdata[7:6] == 2'b11)
    else $error("frame end byte is not a row marker");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    store_we && s_take |-> in_pos != rd_pos)
    else $error("store write and read hit the same entry");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_pos <= fdr_pkg::POS_LAST)
    else $error("store address out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_fill <= fdr_pkg::NB_W'(fdr_pkg::MAX_BYTES))
    else $error("output packet overfull");

  a_store_write_needs_item: assert property (@(posedge clk) disable iff (rst)
    store_we |-> go)
    else $error("store write without an item in work");
`endif

endmodule
`default_nettype wire

// File: tb/sv/fdr_stream_checker.sv
// stream checker for the frame delta run encoder: predicts bytes from accepted pairs and compares
module fdr_stream_checker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [fdr_pkg::THR_W-1:0] cfg_wdata,
  input  wire logic                      s_axis_tvalid,
  input  wire logic                      s_axis_tready,
  // first_index, first_color, second_index, second_color, zero fill
  input  wire logic [fdr_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // operation
  input  wire logic                      s_axis_tuser,
  input  wire logic                      m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // byte_value
  input  wire logic [7:0]                m_axis_tdata,
  // byte_kind
  input  wire logic                      m_axis_tuser,
  input  wire logic                      m_axis_tlast,
  output int                             bytes_due,
  output int                             fail_count
);
  import fdr_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } enc_byte_t;

  logic [ENTRY_W-1:0] ref_colors [STORE_DEPTH];
  enc_byte_t          due_bytes [$];
  logic [THR_W-1:0]   threshold;
  int                 col;
  int                 row;
  logic               in_skip;
  logic [7:0]         skip_run;
  logic [7:0]         copy_run;
  logic [7:0]         marker;
  logic               marker_held;
  int                 errors = 0;

  assign fail_count = errors;

  function automatic logic color_close(logic [COLOR_W-1:0] now, logic [COLOR_W-1:0] old);
    int total;
    int a;
    int b;
    total = 0;
    for (int ch = 0; ch < 3; ch++) begin
      a = now[ch*CHAN_W +: CHAN_W];
      b = old[ch*CHAN_W +: CHAN_W];
      total += (ch == 1 ? 2 : 1) * (a >= b ? a - b : b - a);
    end
    return total <= int'(threshold);
  endfunction

  function automatic void queue_byte(logic kind, logic [7:0] value, logic last);
    enc_byte_t b;
    b.kind  = kind;
    b.value = value;
    b.last  = last;
    due_bytes.push_back(b);
  endfunction

  function automatic void release_marker();
    if (marker_held) queue_byte(KIND_CTRL, marker, 1'b0);
    marker_held = 1'b0;
  endfunction

  function automatic void emit_byte(logic kind, logic [7:0] value);
    release_marker();
    queue_byte(kind, value, 1'b0);
  endfunction

  function automatic void encode_pair(logic op, logic [IDX_W-1:0] i1, logic [COLOR_W-1:0] c1,
                                      logic [IDX_W-1:0] i2, logic [COLOR_W-1:0] c2);
    int                 pos;
    logic [ENTRY_W-1:0] old;
    logic               same;
    pos = row * PAIRS_PER_ROW + col;
    old = ref_colors[pos];
    if (op == OP_LOAD) begin
      ref_colors[pos] = {c2, c1};
    end else begin
      same = color_close(c1, old[COLOR_W-1:0]) && color_close(c2, old[ENTRY_W-1:COLOR_W]);
      if (same != in_skip) begin
        emit_byte(KIND_CTRL, in_skip ? skip_run : copy_run);
        in_skip  = ~in_skip;
        skip_run = '0;
        copy_run = '0;
      end
      if (!in_skip) begin
        emit_byte(KIND_INDEX, i1);
        emit_byte(KIND_INDEX, i2);
        ref_colors[pos] = {c2, c1};
        copy_run = copy_run + 8'd1;
      end else begin
        skip_run = skip_run + 8'd1;
      end
    end
    col++;
    if (col >= PAIRS_PER_ROW) begin
      col = 0;
      if (op == OP_DELTA) begin
        if (!in_skip) emit_byte(KIND_CTRL, copy_run);
        if (in_skip && skip_run == FULL_SKIP && marker_held && marker != MARK_MAX) begin
          marker = marker + 8'd1;
        end else begin
          release_marker();
          marker      = ROW_MARK;
          marker_held = 1'b1;
        end
      end
      in_skip  = 1'b1;
      skip_run = '0;
      copy_run = '0;
      row++;
      if (row >= ROWS_PER_FRAME) begin
        row = 0;
        if (op == OP_DELTA && marker_held) queue_byte(KIND_CTRL, marker, 1'b1);
        marker_held = 1'b0;
      end
    end
  endfunction

  always @(posedge clk) begin : observe
    enc_byte_t seen;
    enc_byte_t want;
    if (rst) begin
      threshold   = '0;
      col         = 0;
      row         = 0;
      in_skip     = 1'b1;
      skip_run    = '0;
      copy_run    = '0;
      marker      = '0;
      marker_held = 1'b0;
      due_bytes.delete();
      bytes_due <= 0;
    end else begin
      if (cfg_we) threshold = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind  = m_axis_tuser;
        seen.value = m_axis_tdata;
        seen.last  = m_axis_tlast;
        if (due_bytes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected byte: kind %0d value %02h last %0d",
                     seen.kind, seen.value, seen.last);
        end else begin
          want = due_bytes.pop_front();
          if (seen.kind !== want.kind || seen.value !== want.value || seen.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("byte mismatch: expected kind %0d value %02h last %0d,",
                       want.kind, want.value, want.last,
                       " got kind %0d value %02h last %0d",
                       seen.kind, seen.value, seen.last);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        encode_pair(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[22:8],
                    s_axis_tdata[30:23], s_axis_tdata[45:31]);
      bytes_due <= due_bytes.size();
    end
  end

endmodule

// File: tb/sv/tb_frame_delta_run_encoder_top.sv
// testbench top for the frame delta run encoder: stimulus, idling, watchdog and verdict
module tb_frame_delta_run_encoder_top;
  import fdr_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int THR_MAX     = 4095;

  typedef enum int {ROW_LOAD, ROW_SAME, ROW_DENSE, ROW_MIXED} row_kind_e;
  typedef enum int {PIX_EXACT, PIX_NEAR, PIX_FAR} pix_mode_e;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [THR_W-1:0]     cfg_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  int                   bytes_due;
  int                   fail_count;

  logic [ENTRY_W-1:0]   frame_colors [STORE_DEPTH];
  int                   thr_now = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   hold_asks = 0;
  int                   quiet_cycles = 0;

  frame_delta_run_encoder_top u_top (.*);
  fdr_stream_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : receiver
    int hold_seen;
    int hold_left;
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic int color_gap(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
    int gap;
    int x;
    int y;
    gap = 0;
    for (int ch = 0; ch < 3; ch++) begin
      x = a[ch*CHAN_W +: CHAN_W];
      y = b[ch*CHAN_W +: CHAN_W];
      gap += (ch == 1 ? 2 : 1) * (x >= y ? x - y : y - x);
    end
    return gap;
  endfunction

  function automatic logic [COLOR_W-1:0] fresh_color();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 15'h7fff : 15'h0000;
    return 15'($urandom);
  endfunction

  function automatic logic [IDX_W-1:0] fresh_index();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hff : 8'h00;
    return 8'($urandom);
  endfunction

  // near colors move one channel by up to about the threshold, so both sides of it get hit
  function automatic logic [COLOR_W-1:0] vary_color(logic [COLOR_W-1:0] old, pix_mode_e mode);
    logic [COLOR_W-1:0] c;
    int ch;
    int span;
    int v;
    int k;
    c = old;
    if (mode == PIX_FAR) begin
      c = fresh_color();
    end else if (mode == PIX_NEAR) begin
      ch   = $urandom_range(2);
      span = thr_now / (ch == 1 ? 2 : 1) + 1;
      k    = $urandom_range(span > 31 ? 31 : span);
      v    = old[ch*CHAN_W +: CHAN_W];
      if ($urandom_range(1) && v + k <= 31) v = v + k;
      else if (v >= k) v = v - k;
      else v = (v + k > 31) ? 31 : v + k;
      c[ch*CHAN_W +: CHAN_W] = 5'(v);
    end
    return c;
  endfunction

  function automatic pix_mode_e pick_mode(logic changed);
    int r;
    r = $urandom_range(9);
    if (changed) return (r < 6) ? PIX_FAR : (r < 9) ? PIX_NEAR : PIX_EXACT;
    return (r < 8) ? PIX_EXACT : PIX_NEAR;
  endfunction

  task automatic push_pair(logic op, logic [IDX_W-1:0] i1, logic [COLOR_W-1:0] c1,
                           logic [IDX_W-1:0] i2, logic [COLOR_W-1:0] c2);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, c2, i2, c1, i1};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic load_pair(int pos);
    logic [COLOR_W-1:0] c1;
    logic [COLOR_W-1:0] c2;
    c1 = fresh_color();
    c2 = fresh_color();
    frame_colors[pos] = {c2, c1};
    push_pair(OP_LOAD, fresh_index(), c1, fresh_index(), c2);
  endtask

  task automatic delta_pair(int pos, pix_mode_e m1, pix_mode_e m2);
    logic [ENTRY_W-1:0] old;
    logic [COLOR_W-1:0] c1;
    logic [COLOR_W-1:0] c2;
    old = frame_colors[pos];
    c1  = vary_color(old[COLOR_W-1:0], m1);
    c2  = vary_color(old[ENTRY_W-1:COLOR_W], m2);
    // changed pairs overwrite the stored reference
    if (color_gap(c1, old[COLOR_W-1:0]) > thr_now ||
        color_gap(c2, old[ENTRY_W-1:COLOR_W]) > thr_now)
      frame_colors[pos] = {c2, c1};
    push_pair(OP_DELTA, fresh_index(), c1, fresh_index(), c2);
  endtask

  task automatic send_row(row_kind_e kind, int row);
    int   pos;
    int   run_left;
    logic changed;
    logic op;
    run_left = 0;
    changed  = 1'b0;
    for (int col = 0; col < PAIRS_PER_ROW; col++) begin
      pos = row * PAIRS_PER_ROW + col;
      if (run_left == 0) begin
        run_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        changed  = $urandom_range(1);
      end
      run_left--;
      case (kind)
        ROW_LOAD:  op = OP_LOAD;
        ROW_MIXED: op = ($urandom_range(99) < 30) ? OP_LOAD : OP_DELTA;
        default:   op = OP_DELTA;
      endcase
      if (op == OP_LOAD) begin
        load_pair(pos);
      end else if (kind == ROW_SAME) begin
        if (thr_now >= 124) delta_pair(pos, PIX_FAR, PIX_FAR);
        else delta_pair(pos, PIX_EXACT, PIX_EXACT);
      end else begin
        delta_pair(pos, pick_mode(changed), pick_mode(changed));
      end
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(int value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= THR_W'(value);
    @(posedge clk);
    cfg_we  <= 1'b0;
    thr_now = value;
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(3))
      0:       return 0;
      1:       return THR_MAX;
      2:       return $urandom_range(1, 40);
      default: return $urandom_range(41, THR_MAX - 1);
    endcase
  endfunction

  function automatic row_kind_e random_kind();
    int r;
    r = $urandom_range(99);
    if (r < 50) return ROW_LOAD;
    if (r < 75) return ROW_SAME;
    if (r < 88) return ROW_DENSE;
    return ROW_MIXED;
  endfunction

  // opening rows, a long unchanged stretch that saturates the marker, then sparse activity
  function automatic row_kind_e second_frame_kind(int r);
    if (r <= 2 || r == 8 || (r >= 10 && r <= 77) || r == 178) return ROW_SAME;
    if ((r >= 3 && r <= 5) || r == 9 || r == 78) return ROW_DENSE;
    if (r == 6) return ROW_MIXED;
    if (r == 7 || r == 179) return ROW_LOAD;
    case (r % 12)
      0:       return ROW_DENSE;
      3:       return ROW_SAME;
      6:       return ROW_MIXED;
      default: return ROW_LOAD;
    endcase
  endfunction

  initial begin : stimulus
    row_kind_e kind;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 26;
    recv_idle_pct <= 78;
    write_threshold($urandom_range(1, 20));

    for (int r = 0; r < ROWS_PER_FRAME; r++) send_row(ROW_LOAD, r);

    for (int r = 0; r < ROWS_PER_FRAME; r++) begin
      if (r == 3) begin
        write_threshold(0);
        hold_asks <= hold_asks + 1;
      end else if (r == 8) begin
        settle();
      end else if (r == 10) begin
        write_threshold(THR_MAX);
      end else if (r == 78) begin
        write_threshold($urandom_range(1, 124));
      end else if (r == 79) begin
        send_idle_pct = 78;
        recv_idle_pct <= 26;
      end
      send_row(second_frame_kind(r), r);
    end

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    for (int r = 0; r < ROWS_PER_FRAME; r++) begin
      if (r % 30 == 0) write_threshold(pick_threshold());
      kind = random_kind();
      if (r == ROWS_PER_FRAME - 1) kind = $urandom_range(1) ? ROW_SAME : ROW_DENSE;
      send_row(kind, r);
    end

    for (int r = 0; r < 3; r++) send_row(random_kind(), r);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/fdr_pkg.sv
src/fdr_ram.sv
src/fdr_encode.sv
src/fdr_out.sv
src/frame_delta_run_encoder_top.sv
tb/sv/fdr_stream_checker.sv
tb/sv/tb_frame_delta_run_encoder_top.sv
